// ===== rtl/touch_sample_average_calibrate_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the touch sample averaging and calibration block.
// Each macro expands to one labelled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef TOUCH_SAMPLE_AVERAGE_CALIBRATE_ASSERT_SVH
`define TOUCH_SAMPLE_AVERAGE_CALIBRATE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSAC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSAC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tsac_pkg.sv =====
// ----------------------------------------------------------------------------
// tsac_pkg
// Widths, register indexes, mode bits, sequencer states and shared helpers
// for the touch sample averaging and calibration block.
// ----------------------------------------------------------------------------
package tsac_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 16;
  localparam int POINT_W    = 10;
  localparam int SIZE_W     = 11;
  localparam int MODE_W     = 5;
  localparam int OFFSET_W   = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 24;

  localparam int DVD_W     = 24;
  localparam int DVS_W     = 12;
  localparam int DIV_STEPS = 2;

  localparam int MAX_SAMPLES_DEF = 8;
  localparam int OFFSET_X_DEF    = 0;
  localparam int OFFSET_Y_DEF    = 0;

  localparam logic [SIZE_W-1:0] SCREEN_MAX = 11'd1024;

  localparam logic [CFG_ADDR_W-1:0] REG_RAW_MIN_X     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RAW_MAX_X     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RAW_MIN_Y     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RAW_MAX_Y     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PRESSURE  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE_BITS     = 3'd7;

  localparam logic [SAMPLE_W-1:0] RST_RAW_MIN       = 12'd0;
  localparam logic [SAMPLE_W-1:0] RST_RAW_MAX       = 12'd4095;
  localparam logic [SIZE_W-1:0]   RST_SCREEN_WIDTH  = 11'd320;
  localparam logic [SIZE_W-1:0]   RST_SCREEN_HEIGHT = 11'd240;
  localparam logic [SAMPLE_W-1:0] RST_MIN_PRESSURE  = 12'd0;
  localparam logic [MODE_W-1:0]   RST_MODE_BITS     = 5'd0;

  localparam int MODE_ENABLE = 0;
  localparam int MODE_SWAP   = 1;
  localparam int MODE_INV_X  = 2;
  localparam int MODE_INV_Y  = 3;
  localparam int MODE_FLIP   = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_X,
    ST_AVG_Y,
    ST_MUL,
    ST_DIV,
    ST_MAP,
    ST_DONE
  } tsac_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Largest screen coordinate of an axis, with the size saturated to 1024.
  function automatic logic [POINT_W-1:0] axis_top(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] sat;
    sat = (size > SCREEN_MAX) ? SCREEN_MAX : size;
    return POINT_W'(sat - SIZE_W'(1));
  endfunction

endpackage

// ===== rtl/tsac_div.sv =====
// ----------------------------------------------------------------------------
// tsac_div
// Shared unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tsac_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tsac_pkg::DVD_W-1:0]  dividend,
  input  logic [tsac_pkg::DVS_W-1:0]  divisor,
  output tsac_pkg::div_status_t       status,
  output logic [tsac_pkg::DVD_W-1:0]  quotient
);

  localparam int DVD_W  = tsac_pkg::DVD_W;
  localparam int DVS_W  = tsac_pkg::DVS_W;
  localparam int STEPS  = tsac_pkg::DIV_STEPS;
  localparam int ITERS  = DVD_W / STEPS;
  localparam int ITER_W = $clog2(ITERS);

  logic [DVS_W:0]    rem;
  logic [DVD_W-1:0]  quo;
  logic [DVS_W-1:0]  dvs;
  logic [ITER_W-1:0] iter;
  logic              busy;
  logic              done;
  logic [DVS_W:0]    rem_next;
  logic [DVD_W-1:0]  quo_next;

  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < STEPS; i++) begin
      rem_next = {rem_next[DVS_W-1:0], quo_next[DVD_W-1]};
      quo_next = {quo_next[DVD_W-2:0], 1'b0};
      if (rem_next >= {1'b0, dvs}) begin
        rem_next    = rem_next - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        iter <= ITER_W'(ITERS - 1);
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        if (iter == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter - ITER_W'(1);
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

// ===== rtl/tsac_map.sv =====
// ----------------------------------------------------------------------------
// tsac_map
// Finishes one axis: clamps the scaled quotient, inverts, adds the offset,
// clamps again and flips.
// ----------------------------------------------------------------------------
module tsac_map (
  input  logic [tsac_pkg::DVD_W-1:0]           quotient,
  input  logic                                 neg,
  input  logic                                 lo_eq_hi,
  input  logic [tsac_pkg::SIZE_W-1:0]          size,
  input  logic                                 inv,
  input  logic                                 flip,
  input  logic signed [tsac_pkg::OFFSET_W-1:0] offset,
  output logic [tsac_pkg::POINT_W-1:0]         point
);

  localparam int POINT_W  = tsac_pkg::POINT_W;
  localparam int DVD_W    = tsac_pkg::DVD_W;
  localparam int OFFSET_W = tsac_pkg::OFFSET_W;
  localparam int SUM_S_W  = POINT_W + 2;

  logic [POINT_W-1:0]        top;
  logic [POINT_W-1:0]        scaled;
  logic [POINT_W-1:0]        shifted;
  logic signed [SUM_S_W-1:0] sum_s;
  logic signed [SUM_S_W-1:0] top_s;

  always_comb begin
    top = tsac_pkg::axis_top(size);
    priority if (lo_eq_hi || neg) begin
      scaled = '0;
    end else if (quotient > DVD_W'(top)) begin
      scaled = top;
    end else begin
      scaled = quotient[POINT_W-1:0];
    end
    if (inv && !lo_eq_hi) begin
      scaled = top - scaled;
    end
    sum_s = $signed({2'b00, scaled})
          + $signed({{(SUM_S_W - OFFSET_W){offset[OFFSET_W-1]}}, offset});
    top_s = $signed({2'b00, top});
    priority if (sum_s < 0) begin
      shifted = '0;
    end else if (sum_s > top_s) begin
      shifted = top;
    end else begin
      shifted = sum_s[POINT_W-1:0];
    end
    if (size == '0) begin
      point = '0;
    end else if (flip) begin
      point = top - shifted;
    end else begin
      point = shifted;
    end
  end

endmodule

// ===== rtl/touch_sample_average_calibrate.sv =====
// ----------------------------------------------------------------------------
// touch_sample_average_calibrate
// Averages qualifying raw touch samples of a burst and maps the mean point
// linearly onto screen coordinates.
// ----------------------------------------------------------------------------
// Raw samples arrive on the s_axis channel, one per transfer, with tlast on
// the final sample of a burst. A touched sample that meets the pressure
// threshold while fewer than MAX_SAMPLES are summed is added to the running
// sums; a non-final sample leaves the block idle. The final sample gives one
// transfer on m_axis: tuser high with the new point when samples qualified
// and the block is enabled, otherwise tuser low with the held point.
// A pressed burst runs two averaging divisions and, per axis, one multiply,
// one scaling division unless the raw span of that axis is empty, and one
// finishing step; the divisions share a single divider that produces two
// quotient bits a cycle. The result is loaded from the done state into the
// output register once that register is free, as the block returns to idle
// to take the next sample; a released burst goes from its final sample
// straight to the done state.
// s_axis_tready is low while a burst is worked on and while a finished result
// cannot enter the output register. A stalled receiver holds the result in
// that register; further non-final samples are still taken meanwhile.
// Reset restores the default calibration and clears sums and held point.
// Configuration may only be written while no burst is being worked on.
// ----------------------------------------------------------------------------
`include "touch_sample_average_calibrate_assert.svh"

module touch_sample_average_calibrate #(
  parameter int MAX_SAMPLES = tsac_pkg::MAX_SAMPLES_DEF,
  parameter int OFFSET_X    = tsac_pkg::OFFSET_X_DEF,
  parameter int OFFSET_Y    = tsac_pkg::OFFSET_Y_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample_x, sample_y, sample_pressure, zero fill
  input  logic [tsac_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // sample_touched
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // point_x, point_y, zero fill
  output logic [tsac_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // pressed
  output logic                              m_axis_tuser,
  input  logic                              cfg_we,
  input  logic [tsac_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tsac_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SAMPLE_W = tsac_pkg::SAMPLE_W;
  localparam int SUM_W    = tsac_pkg::SUM_W;
  localparam int POINT_W  = tsac_pkg::POINT_W;
  localparam int SIZE_W   = tsac_pkg::SIZE_W;
  localparam int MODE_W   = tsac_pkg::MODE_W;
  localparam int OFFSET_W = tsac_pkg::OFFSET_W;
  localparam int DVD_W    = tsac_pkg::DVD_W;
  localparam int DVS_W    = tsac_pkg::DVS_W;
  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = DIFF_W + POINT_W + 1;
  localparam int FILL_W   = tsac_pkg::M_TDATA_W - 2 * POINT_W;

  logic [SAMPLE_W-1:0] raw_min_x;
  logic [SAMPLE_W-1:0] raw_max_x;
  logic [SAMPLE_W-1:0] raw_min_y;
  logic [SAMPLE_W-1:0] raw_max_y;
  logic [SIZE_W-1:0]   screen_width;
  logic [SIZE_W-1:0]   screen_height;
  logic [SAMPLE_W-1:0] min_pressure;
  logic [MODE_W-1:0]   mode_bits;

  tsac_pkg::tsac_state_t state;
  tsac_pkg::tsac_state_t state_next;

  logic [SUM_W-1:0]    sum_x;
  logic [SUM_W-1:0]    sum_y;
  logic [CNT_W-1:0]    count;
  logic [SUM_W-1:0]    sum_x_next;
  logic [SUM_W-1:0]    sum_y_next;
  logic [CNT_W-1:0]    count_next;
  logic [POINT_W-1:0]  held_x;
  logic [POINT_W-1:0]  held_y;
  logic [SAMPLE_W-1:0] avg_x;
  logic [SAMPLE_W-1:0] avg_y;
  logic                pressed;
  logic                axis_sel;
  logic [DVD_W-1:0]    prod_mag;
  logic [DVS_W-1:0]    den_mag;
  logic                neg;
  logic                lo_eq_hi;

  logic [SAMPLE_W-1:0] sample_x;
  logic [SAMPLE_W-1:0] sample_y;
  logic [SAMPLE_W-1:0] sample_pressure;
  logic                s_fire;
  logic                qual;
  logic                out_free;
  logic                out_load;
  logic                enabled;

  logic [SAMPLE_W-1:0]      cur_raw;
  logic [SAMPLE_W-1:0]      cur_lo;
  logic [SAMPLE_W-1:0]      cur_hi;
  logic [SIZE_W-1:0]        cur_size;
  logic                     cur_inv;
  logic signed [OFFSET_W-1:0] cur_offset;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] den;
  logic signed [DIFF_W-1:0] den_abs;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_abs;
  logic                     cur_lo_eq_hi;
  logic [POINT_W-1:0]       map_point;

  logic                  div_start;
  logic [DVD_W-1:0]      div_dividend;
  logic [DVS_W-1:0]      div_divisor;
  tsac_pkg::div_status_t div_stat;
  logic [DVD_W-1:0]      div_quotient;

  assign sample_x        = s_axis_tdata[SAMPLE_W-1:0];
  assign sample_y        = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign sample_pressure = s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
  assign s_fire          = s_axis_tvalid && s_axis_tready;
  assign out_free        = !m_axis_tvalid || m_axis_tready;
  assign enabled         = mode_bits[tsac_pkg::MODE_ENABLE];

  always_comb begin
    qual = s_axis_tuser && (sample_pressure >= min_pressure)
        && (count < CNT_W'(MAX_SAMPLES));
    if (qual) begin
      sum_x_next = sum_x + SUM_W'(sample_x);
      sum_y_next = sum_y + SUM_W'(sample_y);
      count_next = count + CNT_W'(1);
    end else begin
      sum_x_next = sum_x;
      sum_y_next = sum_y;
      count_next = count;
    end
  end

  always_comb begin
    if (axis_sel) begin
      cur_raw    = mode_bits[tsac_pkg::MODE_SWAP] ? avg_x : avg_y;
      cur_lo     = raw_min_y;
      cur_hi     = raw_max_y;
      cur_size   = screen_height;
      cur_inv    = mode_bits[tsac_pkg::MODE_INV_Y];
      cur_offset = OFFSET_W'(OFFSET_Y);
    end else begin
      cur_raw    = mode_bits[tsac_pkg::MODE_SWAP] ? avg_y : avg_x;
      cur_lo     = raw_min_x;
      cur_hi     = raw_max_x;
      cur_size   = screen_width;
      cur_inv    = mode_bits[tsac_pkg::MODE_INV_X];
      cur_offset = OFFSET_W'(OFFSET_X);
    end
    diff         = $signed({1'b0, cur_raw}) - $signed({1'b0, cur_lo});
    den          = $signed({1'b0, cur_hi}) - $signed({1'b0, cur_lo});
    den_abs      = den[DIFF_W-1] ? -den : den;
    prod         = PROD_W'(diff)
                 * PROD_W'($signed({1'b0, tsac_pkg::axis_top(cur_size)}));
    prod_abs     = prod[PROD_W-1] ? -prod : prod;
    cur_lo_eq_hi = (cur_lo == cur_hi);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tsac_pkg::ST_IDLE: begin
        if (s_fire && s_axis_tlast) begin
          state_next = (enabled && count_next != '0) ? tsac_pkg::ST_AVG_X
                                                     : tsac_pkg::ST_DONE;
        end
      end
      tsac_pkg::ST_AVG_X: begin
        if (div_stat.done) begin
          state_next = tsac_pkg::ST_AVG_Y;
        end
      end
      tsac_pkg::ST_AVG_Y: begin
        if (div_stat.done) begin
          state_next = tsac_pkg::ST_MUL;
        end
      end
      tsac_pkg::ST_MUL: begin
        state_next = cur_lo_eq_hi ? tsac_pkg::ST_MAP : tsac_pkg::ST_DIV;
      end
      tsac_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = tsac_pkg::ST_MAP;
        end
      end
      tsac_pkg::ST_MAP: begin
        state_next = axis_sel ? tsac_pkg::ST_DONE : tsac_pkg::ST_MUL;
      end
      tsac_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tsac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tsac_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = (state == tsac_pkg::ST_IDLE);
    out_load      = (state == tsac_pkg::ST_DONE) && out_free;
    div_start     = 1'b0;
    div_dividend  = prod_mag;
    div_divisor   = den_mag;
    unique case (state)
      tsac_pkg::ST_AVG_X: begin
        div_start    = !div_stat.busy && !div_stat.done;
        div_dividend = DVD_W'(sum_x);
        div_divisor  = DVS_W'(count);
      end
      tsac_pkg::ST_AVG_Y: begin
        div_start    = !div_stat.busy && !div_stat.done;
        div_dividend = DVD_W'(sum_y);
        div_divisor  = DVS_W'(count);
      end
      tsac_pkg::ST_DIV: begin
        div_start = !div_stat.busy && !div_stat.done;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_min_x     <= tsac_pkg::RST_RAW_MIN;
      raw_max_x     <= tsac_pkg::RST_RAW_MAX;
      raw_min_y     <= tsac_pkg::RST_RAW_MIN;
      raw_max_y     <= tsac_pkg::RST_RAW_MAX;
      screen_width  <= tsac_pkg::RST_SCREEN_WIDTH;
      screen_height <= tsac_pkg::RST_SCREEN_HEIGHT;
      min_pressure  <= tsac_pkg::RST_MIN_PRESSURE;
      mode_bits     <= tsac_pkg::RST_MODE_BITS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tsac_pkg::REG_RAW_MIN_X:     raw_min_x     <= cfg_wdata[SAMPLE_W-1:0];
        tsac_pkg::REG_RAW_MAX_X:     raw_max_x     <= cfg_wdata[SAMPLE_W-1:0];
        tsac_pkg::REG_RAW_MIN_Y:     raw_min_y     <= cfg_wdata[SAMPLE_W-1:0];
        tsac_pkg::REG_RAW_MAX_Y:     raw_max_y     <= cfg_wdata[SAMPLE_W-1:0];
        tsac_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_wdata[SIZE_W-1:0];
        tsac_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_wdata[SIZE_W-1:0];
        tsac_pkg::REG_MIN_PRESSURE:  min_pressure  <= cfg_wdata[SAMPLE_W-1:0];
        tsac_pkg::REG_MODE_BITS:     mode_bits     <= cfg_wdata[MODE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tsac_pkg::ST_IDLE;
      sum_x         <= '0;
      sum_y         <= '0;
      count         <= '0;
      held_x        <= '0;
      held_y        <= '0;
      pressed       <= 1'b0;
      axis_sel      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (s_fire) begin
        sum_x   <= sum_x_next;
        sum_y   <= sum_y_next;
        count   <= count_next;
        pressed <= enabled && (count_next != '0);
      end
      if (state == tsac_pkg::ST_AVG_X && div_stat.done) begin
        avg_x <= div_quotient[SAMPLE_W-1:0];
      end
      if (state == tsac_pkg::ST_AVG_Y && div_stat.done) begin
        avg_y    <= div_quotient[SAMPLE_W-1:0];
        axis_sel <= 1'b0;
      end
      if (state == tsac_pkg::ST_MUL) begin
        prod_mag <= DVD_W'(prod_abs);
        den_mag  <= den_abs[DVS_W-1:0];
        neg      <= diff[DIFF_W-1] ^ den[DIFF_W-1];
        lo_eq_hi <= cur_lo_eq_hi;
      end
      if (state == tsac_pkg::ST_MAP) begin
        if (axis_sel) begin
          held_y <= map_point;
        end else begin
          held_x <= map_point;
        end
        axis_sel <= 1'b1;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {{FILL_W{1'b0}}, held_y, held_x};
        m_axis_tuser  <= pressed;
        sum_x         <= '0;
        sum_y         <= '0;
        count         <= '0;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  tsac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_stat),
    .quotient (div_quotient)
  );

  tsac_map u_map (
    .quotient (div_quotient),
    .neg      (neg),
    .lo_eq_hi (lo_eq_hi),
    .size     (cur_size),
    .inv      (cur_inv),
    .flip     (mode_bits[tsac_pkg::MODE_FLIP]),
    .offset   (cur_offset),
    .point    (map_point)
  );

  `TSAC_ASSERT_IMP(a_count_bound, clk, rst, state == tsac_pkg::ST_IDLE,
                   count <= CNT_W'(MAX_SAMPLES), "sample count above limit")

  `TSAC_ASSERT_IMP(a_start_idle, clk, rst, div_start, !div_stat.busy,
                   "divider started while busy")

  `TSAC_ASSERT_IMP(a_map_idle, clk, rst, state == tsac_pkg::ST_MAP,
                   !div_stat.busy, "axis finished while divider busy")

  `TSAC_ASSERT_NXT(a_result_load, clk, rst, out_load,
                   m_axis_tvalid && state == tsac_pkg::ST_IDLE,
                   "result not presented after burst end")

endmodule

// ===== sim/touch_report_checker.sv =====
// ----------------------------------------------------------------------------
// touch_report_checker
// Watches the sample, report and configuration ports of the touch averaging
// and calibration block. It keeps its own copy of the calibration registers,
// the burst sums and the held point, and predicts one report for every
// accepted end-of-burst sample. Each report transfer is compared field by
// field with the oldest prediction. Mismatches, unexpected reports and
// predictions still waiting are returned to the top as a fault count.
// ----------------------------------------------------------------------------
module touch_report_checker #(
  parameter int MAX_SAMPLES = tsac_pkg::MAX_SAMPLES_DEF,
  parameter int OFFSET_X    = tsac_pkg::OFFSET_X_DEF,
  parameter int OFFSET_Y    = tsac_pkg::OFFSET_Y_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [tsac_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tlast,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [tsac_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                            m_axis_tuser,
  input  logic                            cfg_we,
  input  logic [tsac_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tsac_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fault_count,
  output int                              report_count,
  output int                              pressed_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = tsac_pkg::SAMPLE_W;
  localparam int SUM_W    = tsac_pkg::SUM_W;
  localparam int POINT_W  = tsac_pkg::POINT_W;
  localparam int SIZE_W   = tsac_pkg::SIZE_W;
  localparam int MODE_W   = tsac_pkg::MODE_W;

  typedef struct packed {
    logic               pressed;
    logic [POINT_W-1:0] px;
    logic [POINT_W-1:0] py;
  } touch_report_t;

  logic [SAMPLE_W-1:0] raw_min_x, raw_max_x, raw_min_y, raw_max_y;
  logic [SIZE_W-1:0]   width, height;
  logic [SAMPLE_W-1:0] min_press;
  logic [MODE_W-1:0]   mode;

  logic [SUM_W-1:0]    acc_x, acc_y;
  logic [4:0]          acc_n;
  logic [POINT_W-1:0]  held_x, held_y;

  touch_report_t       expected_reports[$];
  int                  mismatches = 0;
  int                  seen = 0;
  int                  pressed_seen = 0;

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [POINT_W-1:0] scale_axis(
    input logic [SAMPLE_W-1:0] raw,
    input logic [SAMPLE_W-1:0] lo,
    input logic [SAMPLE_W-1:0] hi,
    input logic [SIZE_W-1:0]   size,
    input logic                inv,
    input int                  offset,
    input logic                flip
  );
    logic [SIZE_W-1:0] sz;
    int                last_px;
    int                m;
    sz = (size > tsac_pkg::SCREEN_MAX) ? tsac_pkg::SCREEN_MAX : size;
    if (sz == '0) return '0;
    last_px = int'(sz) - 1;
    if (lo == hi) begin
      m = 0;
    end else begin
      m = ((int'(raw) - int'(lo)) * last_px) / (int'(hi) - int'(lo));
      m = clip(m, 0, last_px);
      if (inv) m = last_px - m;
    end
    m = clip(m + offset, 0, last_px);
    if (flip) m = last_px - m;
    return m[POINT_W-1:0];
  endfunction

  always @(posedge clk) begin
    touch_report_t       got;
    touch_report_t       want;
    logic [SAMPLE_W-1:0] sx, sy, sp, ax, ay, swap_tmp;
    if (rst) begin
      raw_min_x = tsac_pkg::RST_RAW_MIN;
      raw_max_x = tsac_pkg::RST_RAW_MAX;
      raw_min_y = tsac_pkg::RST_RAW_MIN;
      raw_max_y = tsac_pkg::RST_RAW_MAX;
      width     = tsac_pkg::RST_SCREEN_WIDTH;
      height    = tsac_pkg::RST_SCREEN_HEIGHT;
      min_press = tsac_pkg::RST_MIN_PRESSURE;
      mode      = tsac_pkg::RST_MODE_BITS;
      acc_x     = '0;
      acc_y     = '0;
      acc_n     = '0;
      held_x    = '0;
      held_y    = '0;
      expected_reports.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.pressed = m_axis_tuser;
        got.px      = m_axis_tdata[POINT_W-1:0];
        got.py      = m_axis_tdata[2*POINT_W-1:POINT_W];
        seen++;
        if (got.pressed) pressed_seen++;
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected report: pressed=%0b x=%0d y=%0d",
                     $realtime, got.pressed, got.px, got.py);
        end else begin
          want = expected_reports.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] report %0d: expected p=%0b x=%0d y=%0d, got p=%0b x=%0d y=%0d",
                       $realtime, seen, want.pressed, want.px, want.py,
                       got.pressed, got.px, got.py);
          end
        end
      end

      if (cfg_we) begin
        case (cfg_addr)
          tsac_pkg::REG_RAW_MIN_X:     raw_min_x = cfg_wdata;
          tsac_pkg::REG_RAW_MAX_X:     raw_max_x = cfg_wdata;
          tsac_pkg::REG_RAW_MIN_Y:     raw_min_y = cfg_wdata;
          tsac_pkg::REG_RAW_MAX_Y:     raw_max_y = cfg_wdata;
          tsac_pkg::REG_SCREEN_WIDTH:  width     = cfg_wdata[SIZE_W-1:0];
          tsac_pkg::REG_SCREEN_HEIGHT: height    = cfg_wdata[SIZE_W-1:0];
          tsac_pkg::REG_MIN_PRESSURE:  min_press = cfg_wdata;
          tsac_pkg::REG_MODE_BITS:     mode      = cfg_wdata[MODE_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        sx = s_axis_tdata[SAMPLE_W-1:0];
        sy = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
        sp = s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
        if (s_axis_tuser && sp >= min_press && int'(acc_n) < MAX_SAMPLES) begin
          acc_x = acc_x + SUM_W'(sx);
          acc_y = acc_y + SUM_W'(sy);
          acc_n = acc_n + 5'd1;
        end
        if (s_axis_tlast) begin
          if (mode[tsac_pkg::MODE_ENABLE] && acc_n != '0) begin
            ax = SAMPLE_W'(acc_x / SUM_W'(acc_n));
            ay = SAMPLE_W'(acc_y / SUM_W'(acc_n));
            if (mode[tsac_pkg::MODE_SWAP]) begin
              swap_tmp = ax;
              ax       = ay;
              ay       = swap_tmp;
            end
            held_x = scale_axis(ax, raw_min_x, raw_max_x, width,
                                mode[tsac_pkg::MODE_INV_X], OFFSET_X,
                                mode[tsac_pkg::MODE_FLIP]);
            held_y = scale_axis(ay, raw_min_y, raw_max_y, height,
                                mode[tsac_pkg::MODE_INV_Y], OFFSET_Y,
                                mode[tsac_pkg::MODE_FLIP]);
            want.pressed = 1'b1;
          end else begin
            want.pressed = 1'b0;
          end
          want.px = held_x;
          want.py = held_y;
          expected_reports.push_back(want);
          acc_x = '0;
          acc_y = '0;
          acc_n = '0;
        end
      end
    end
    fault_count   <= mismatches + expected_reports.size();
    report_count  <= seen;
    pressed_count <= pressed_seen;
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the touch averaging and calibration block. A
// short directed part covers reset defaults, the coordinate extremes, the
// pressure threshold, the sample limit, disabled operation, empty and
// reversed raw spans and out-of-range screen sizes. Random phases follow,
// each with a fresh calibration written while the block is idle, sending
// mostly well-formed bursts mixed with untouched bursts and noise, under
// random gaps on both channels. The checker beside the block does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W   = tsac_pkg::SAMPLE_W;
  localparam int SIZE_W     = tsac_pkg::SIZE_W;
  localparam int MODE_W     = tsac_pkg::MODE_W;
  localparam int S_TDATA_W  = tsac_pkg::S_TDATA_W;
  localparam int M_TDATA_W  = tsac_pkg::M_TDATA_W;
  localparam int CFG_ADDR_W = tsac_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = tsac_pkg::CFG_DATA_W;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_PHASES = 20;
  localparam int PHASE_ITEMS   = 87;

  typedef struct {
    logic [SAMPLE_W-1:0] min_x;
    logic [SAMPLE_W-1:0] max_x;
    logic [SAMPLE_W-1:0] min_y;
    logic [SAMPLE_W-1:0] max_y;
    logic [SIZE_W-1:0]   width;
    logic [SIZE_W-1:0]   height;
    logic [SAMPLE_W-1:0] min_press;
    logic [MODE_W-1:0]   mode;
  } calib_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fault_count;
  int report_count;
  int pressed_count;
  int samples_sent  = 0;
  int bursts_sent   = 0;
  int settings_done = 0;
  int cycles        = 0;
  int ready_hold    = 0;
  bit fast          = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  touch_sample_average_calibrate i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  touch_report_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fault_count   (fault_count),
    .report_count  (report_count),
    .pressed_count (pressed_count)
  );

  // After each report transfer the receiver holds off for a drawn number of
  // cycles in which a report is waiting.
  always @(posedge clk) begin : report_sink
    int hold;
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      hold = fast ? 0 : $urandom_range(0, 19);
      ready_hold    <= hold;
      m_axis_tready <= (hold == 0);
    end else if (ready_hold != 0) begin
      if (m_axis_tvalid) ready_hold <= ready_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_sample(input bit touched, input logic [SAMPLE_W-1:0] x,
                             input logic [SAMPLE_W-1:0] y,
                             input logic [SAMPLE_W-1:0] p, input bit last);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({p, y, x});
    s_axis_tuser  <= touched;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    samples_sent++;
    if (last) bursts_sent++;
  endtask

  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (report_count < bursts_sent);
  endtask

  task automatic program_calib(input calib_t c);
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    fast      <= ($urandom_range(0, 3) == 0);
    cfg_we    <= 1'b1;
    cfg_addr  <= tsac_pkg::REG_RAW_MIN_X;
    cfg_wdata <= c.min_x;
    @(posedge clk);
    cfg_addr  <= tsac_pkg::REG_RAW_MAX_X;
    cfg_wdata <= c.max_x;
    @(posedge clk);
    cfg_addr  <= tsac_pkg::REG_RAW_MIN_Y;
    cfg_wdata <= c.min_y;
    @(posedge clk);
    cfg_addr  <= tsac_pkg::REG_RAW_MAX_Y;
    cfg_wdata <= c.max_y;
    @(posedge clk);
    cfg_addr  <= tsac_pkg::REG_SCREEN_WIDTH;
    cfg_wdata <= CFG_DATA_W'(c.width);
    @(posedge clk);
    cfg_addr  <= tsac_pkg::REG_SCREEN_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(c.height);
    @(posedge clk);
    cfg_addr  <= tsac_pkg::REG_MIN_PRESSURE;
    cfg_wdata <= c.min_press;
    @(posedge clk);
    cfg_addr  <= tsac_pkg::REG_MODE_BITS;
    cfg_wdata <= CFG_DATA_W'(c.mode);
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_done++;
  endtask

  function automatic void pick_span(output logic [SAMPLE_W-1:0] lo,
                                    output logic [SAMPLE_W-1:0] hi);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      lo = SAMPLE_W'($urandom_range(0, 4095));
      hi = lo;
    end else if (pick == 1) begin
      hi = SAMPLE_W'($urandom_range(0, 2000));
      lo = SAMPLE_W'($urandom_range(int'(hi) + 1, 4095));
    end else if (pick == 2) begin
      lo = '0;
      hi = '1;
    end else begin
      lo = SAMPLE_W'($urandom_range(0, 2000));
      hi = SAMPLE_W'($urandom_range(int'(lo) + 1, 4095));
    end
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return '0;
      1:       return SIZE_W'($urandom_range(1025, 2047));
      2:       return tsac_pkg::SCREEN_MAX;
      3:       return 11'd1;
      default: return SIZE_W'($urandom_range(2, 1024));
    endcase
  endfunction

  function automatic calib_t random_calib();
    calib_t c;
    int     pick;
    pick_span(c.min_x, c.max_x);
    pick_span(c.min_y, c.max_y);
    c.width  = pick_size();
    c.height = pick_size();
    pick = $urandom_range(0, 9);
    if (pick == 0)      c.min_press = '0;
    else if (pick == 1) c.min_press = '1;
    else                c.min_press = SAMPLE_W'($urandom_range(0, 3000));
    c.mode = MODE_W'($urandom_range(0, 31));
    if ($urandom_range(0, 4) != 0) c.mode[tsac_pkg::MODE_ENABLE] = 1'b1;
    return c;
  endfunction

  function automatic logic [SAMPLE_W-1:0] near_span(input logic [SAMPLE_W-1:0] a,
                                                    input logic [SAMPLE_W-1:0] b);
    if ($urandom_range(0, 3) == 0) return SAMPLE_W'($urandom_range(0, 4095));
    return SAMPLE_W'($urandom_range(int'(a), int'(b)));
  endfunction

  function automatic logic [SAMPLE_W-1:0] jitter(input logic [SAMPLE_W-1:0] centre);
    int v;
    v = int'(centre) + int'($urandom_range(0, 64)) - 32;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_burst(input calib_t c);
    int                  len;
    int                  kind;
    bit                  touched;
    logic [SAMPLE_W-1:0] cx, cy, p;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
    kind = $urandom_range(0, 9);
    cx   = near_span(c.min_x, c.max_x);
    cy   = near_span(c.min_y, c.max_y);
    for (int i = 0; i < len; i++) begin
      if (kind == 0) begin
        send_sample(1'($urandom_range(0, 1)),
                    SAMPLE_W'($urandom_range(0, 4095)),
                    SAMPLE_W'($urandom_range(0, 4095)),
                    SAMPLE_W'($urandom_range(0, 4095)),
                    $urandom_range(0, 3) == 0);
      end else begin
        touched = (kind == 1) ? 1'b0 : ($urandom_range(0, 9) != 0);
        p = ($urandom_range(0, 3) != 0)
          ? SAMPLE_W'($urandom_range(int'(c.min_press), 4095))
          : SAMPLE_W'($urandom_range(0, 4095));
        send_sample(touched, jitter(cx), jitter(cy), p, i == len - 1);
      end
    end
  endtask

  initial begin
    calib_t c;
    int     phase_start;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset calibration leaves the block disabled.
    send_sample(1'b1, 12'd1234, 12'd2345, 12'd500, 1'b0);
    send_sample(1'b1, 12'd100, 12'd200, 12'd0, 1'b1);

    c = '{min_x: 12'd0, max_x: 12'd4095, min_y: 12'd0, max_y: 12'd4095,
          width: 11'd320, height: 11'd240, min_press: 12'd100, mode: 5'd0};
    c.mode[tsac_pkg::MODE_ENABLE] = 1'b1;
    program_calib(c);
    send_sample(1'b1, 12'd0, 12'd0, 12'd4095, 1'b1);
    send_sample(1'b1, 12'd4095, 12'd4095, 12'd4095, 1'b1);
    send_sample(1'b0, 12'd2000, 12'd2000, 12'd4095, 1'b1);
    send_sample(1'b1, 12'd1000, 12'd1000, 12'd99, 1'b1);
    send_sample(1'b1, 12'd1000, 12'd3000, 12'd100, 1'b1);
    // Samples beyond the limit of one burst must be ignored.
    for (int i = 0; i < 10; i++) begin
      if (i < 8) send_sample(1'b1, 12'd4095, 12'd0, 12'd4095, 1'b0);
      else       send_sample(1'b1, 12'd0, 12'd4095, 12'd4095, i == 9);
    end

    // Reversed x span, empty y span, zero width and oversized height.
    c = '{min_x: 12'd4095, max_x: 12'd0, min_y: 12'd2048, max_y: 12'd2048,
          width: 11'd0, height: 11'd2047, min_press: 12'd0, mode: 5'h1F};
    program_calib(c);
    send_sample(1'b1, 12'd3000, 12'd500, 12'd2000, 1'b1);
    send_sample(1'b1, 12'd0, 12'd4095, 12'd4095, 1'b0);
    send_sample(1'b1, 12'd4095, 12'd0, 12'd4095, 1'b1);

    // Readings outside the raw span and the highest pressure threshold.
    c = '{min_x: 12'd100, max_x: 12'd3900, min_y: 12'd100, max_y: 12'd3900,
          width: 11'd1024, height: 11'd1024, min_press: 12'd4095, mode: 5'd0};
    c.mode[tsac_pkg::MODE_ENABLE] = 1'b1;
    c.mode[tsac_pkg::MODE_FLIP]   = 1'b1;
    program_calib(c);
    send_sample(1'b1, 12'd50, 12'd4000, 12'd4095, 1'b1);
    send_sample(1'b1, 12'd2000, 12'd2000, 12'd4094, 1'b1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      c = random_calib();
      if (ph == 0) c.mode = '1;
      if (ph == 1) c.mode = '0;
      program_calib(c);
      phase_start = samples_sent;
      while (samples_sent - phase_start < PHASE_ITEMS) begin
        send_burst(c);
        if ($urandom_range(0, 15) == 0) drain_reports();
      end
      send_sample(1'b1, 12'd2048, 12'd2048, 12'd4095, 1'b1);
    end

    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d samples in %0d bursts over %0d calibration settings.",
             samples_sent, bursts_sent, settings_done);
    $display("Checked %0d reports, %0d of them pressed.", report_count, pressed_count);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tsac_pkg.sv
rtl/tsac_div.sv
rtl/tsac_map.sv
rtl/touch_sample_average_calibrate.sv
sim/touch_report_checker.sv
sim/tb_top.sv
